/* sv/gsm_hopping_sequence_generator_top_macros.svh */
// Assertion macros shared by the hopping sequence generator modules.
`ifndef GSM_HOPPING_SEQUENCE_GENERATOR_TOP_MACROS_SVH
`define GSM_HOPPING_SEQUENCE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define GSMHOP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define GSMHOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gsmhop_pkg.sv */
// Package with the types, constants and hopping table of the hopping sequence generator.
package gsmhop_pkg;

  // Largest allocation size supported by default.
  localparam int MAX_ALLOC = 64;

  // Width of the value handed to the remainder pipeline (frame number plus offset).
  localparam int VAL_W = 17;

  // Configuration port geometry.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALLOC_SIZE   = 2'd0,
    REG_INDEX_OFFSET = 2'd1,
    REG_HOP_SEQ      = 2'd2
  } cfg_reg_t;

  // Reset value of the allocation size register.
  localparam logic [CFG_W-1:0] ALLOC_SIZE_RST = 7'd1;

  // Frame counter limits and frame number weights.
  localparam logic [4:0] T2_MAX     = 5'd25;
  localparam logic [5:0] T3_MAX     = 6'd50;
  localparam int         T2_MOD     = 26;
  localparam int         T3_MOD     = 51;
  localparam int         T1_WEIGHT  = 1326;

  // Queue depths between the parts of the block.
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Random hopping table of the standard.
  localparam int RN_DEPTH = 114;
  localparam logic [6:0] RN_LAST = 7'(RN_DEPTH - 1);
  localparam logic [6:0] RN_TABLE [RN_DEPTH] = '{
    7'd48,  7'd98,  7'd63,  7'd1,   7'd36,  7'd95,  7'd78,  7'd102, 7'd94,  7'd73,
    7'd0,   7'd64,  7'd25,  7'd81,  7'd76,  7'd59,  7'd124, 7'd23,  7'd104, 7'd100,
    7'd101, 7'd47,  7'd118, 7'd85,  7'd18,  7'd56,  7'd96,  7'd86,  7'd54,  7'd2,
    7'd80,  7'd34,  7'd127, 7'd13,  7'd6,   7'd89,  7'd57,  7'd103, 7'd12,  7'd74,
    7'd55,  7'd111, 7'd75,  7'd38,  7'd109, 7'd71,  7'd112, 7'd29,  7'd11,  7'd88,
    7'd87,  7'd19,  7'd3,   7'd68,  7'd110, 7'd26,  7'd33,  7'd31,  7'd8,   7'd45,
    7'd82,  7'd58,  7'd40,  7'd107, 7'd32,  7'd5,   7'd106, 7'd92,  7'd62,  7'd67,
    7'd77,  7'd108, 7'd122, 7'd37,  7'd60,  7'd66,  7'd121, 7'd42,  7'd51,  7'd126,
    7'd117, 7'd114, 7'd4,   7'd90,  7'd43,  7'd52,  7'd53,  7'd113, 7'd120, 7'd72,
    7'd16,  7'd49,  7'd7,   7'd79,  7'd119, 7'd61,  7'd22,  7'd84,  7'd9,   7'd97,
    7'd91,  7'd15,  7'd21,  7'd24,  7'd46,  7'd39,  7'd93,  7'd105, 7'd65,  7'd70,
    7'd125, 7'd99,  7'd17,  7'd123
  };

  // Table read; indexes past the end read the last entry.
  function automatic logic [6:0] rn_lookup(input logic [6:0] idx);
    logic [6:0] safe_idx;
    safe_idx  = (idx > RN_LAST) ? RN_LAST : idx;
    rn_lookup = RN_TABLE[safe_idx];
  endfunction

  // Input beat: the three TDMA frame counters.
  typedef struct packed {
    logic [5:0] frame_t1;
    logic [4:0] frame_t2;
    logic [5:0] frame_t3;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [5:0] alloc_index;
    logic       range_error;
  } out_item_t;

  // Classified item between the front and the remainder pipeline.
  typedef struct packed {
    logic             range_error;
    logic [VAL_W-1:0] value;
  } mid_item_t;

endpackage

/* sv/gsm_hopping_sequence_generator_top.sv */
// Top level of the GSM hopping sequence generator: configuration, front, queue and back.
//
//   channel  ports                              beat
//   input    in_push / in_full / in_item        frame_t1, frame_t2, frame_t3
//   result   out_pop / out_empty / out_item     alloc_index, range_error
//   config   cfg_we / cfg_index / cfg_wdata     alloc_size, index_offset, hop_seq_number
//
// One beat is accepted per cycle and one result leaves per cycle in steady state, while
// the result queue has room. A result passes through the input queue and then the
// remainder pipeline (17 compare and subtract steps of shifted N), whose last register
// writes the result queue. When the result queue is full the whole remainder pipeline
// holds, and the input queue fills before in_full rises. Reset is synchronous.
`include "gsm_hopping_sequence_generator_top_macros.svh"

module gsm_hopping_sequence_generator_top #(
  parameter int MAX_ALLOC = gsmhop_pkg::MAX_ALLOC
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  gsmhop_pkg::in_item_t               in_item,
  output logic                               in_full,
  input  logic                               out_pop,
  output logic                               out_empty,
  output gsmhop_pkg::out_item_t              out_item,
  input  logic                               cfg_we,
  input  logic [gsmhop_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsmhop_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int NW = $clog2(MAX_ALLOC + 1);
  localparam logic [gsmhop_pkg::CFG_W-1:0] MAX_ALLOC_CFG = gsmhop_pkg::CFG_W'(MAX_ALLOC);

  logic [gsmhop_pkg::CFG_W-1:0] alloc_size_r;
  logic [5:0]                   index_offset_r;
  logic [5:0]                   hop_seq_number_r;
  logic [NW-1:0]                n_eff;
  gsmhop_pkg::mid_item_t        front_item;
  gsmhop_pkg::mid_item_t        mid_head;
  logic                         mid_empty;
  logic                         mid_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_size_r     <= gsmhop_pkg::ALLOC_SIZE_RST;
      index_offset_r   <= '0;
      hop_seq_number_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsmhop_pkg::REG_ALLOC_SIZE:   alloc_size_r     <= cfg_wdata;
        gsmhop_pkg::REG_INDEX_OFFSET: index_offset_r   <= cfg_wdata[5:0];
        gsmhop_pkg::REG_HOP_SEQ:      hop_seq_number_r <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // Effective allocation size: zero counts as one, large values saturate.
  always_comb begin
    if (alloc_size_r == '0) begin
      n_eff = NW'(1);
    end else if (alloc_size_r > MAX_ALLOC_CFG) begin
      n_eff = NW'(MAX_ALLOC);
    end else begin
      n_eff = NW'(alloc_size_r);
    end
  end

  gsmhop_front #(
    .MAX_ALLOC (MAX_ALLOC)
  ) u_front (
    .item           (in_item),
    .n              (n_eff),
    .index_offset   (index_offset_r),
    .hop_seq_number (hop_seq_number_r),
    .mid_item       (front_item)
  );

  gsmhop_fifo #(
    .WIDTH ($bits(gsmhop_pkg::mid_item_t)),
    .DEPTH (gsmhop_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (front_item),
    .full    (in_full),
    .pop     (mid_pop),
    .rd_data (mid_head),
    .empty   (mid_empty)
  );

  gsmhop_back #(
    .MAX_ALLOC (MAX_ALLOC)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n         (n_eff),
    .mid_valid (!mid_empty),
    .mid_item  (mid_head),
    .mid_pop   (mid_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  `GSMHOP_ASSERT_IMPLIES(a_err_zero, !out_empty && out_item.range_error, out_item.alloc_index == '0, "error beat carries a nonzero index")

endmodule

/* sv/gsmhop_fifo.sv */
// Small register queue used between the parts of the block.
`include "gsm_hopping_sequence_generator_top_macros.svh"

module gsmhop_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage; data needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `GSMHOP_ASSERT_NEXT(a_push_lands, do_push && !do_pop, !empty, "pushed beat was lost")

endmodule

/* sv/gsmhop_front.sv */
// Front part: range check, hopping mode selection and the value to be reduced mod N.
module gsmhop_front #(
  parameter  int MAX_ALLOC = gsmhop_pkg::MAX_ALLOC,
  localparam int NW        = $clog2(MAX_ALLOC + 1)
) (
  input  gsmhop_pkg::in_item_t  item,
  input  logic [NW-1:0]         n,
  input  logic [5:0]            index_offset,
  input  logic [5:0]            hop_seq_number,
  output gsmhop_pkg::mid_item_t mid_item
);

  localparam int VW = gsmhop_pkg::VAL_W;

  logic          range_err;
  logic [6:0]    diff;
  logic [4:0]    t3_t2_mod;
  logic [VW-1:0] frame_num;
  logic [VW-1:0] cyc_val;
  logic [6:0]    rn_idx;
  logic [6:0]    rn_val;
  logic [7:0]    rn_sum;
  logic [7:0]    n8;
  logic [7:0]    mask8;
  logic [7:0]    m8;
  logic [7:0]    t8;
  logic [VW-1:0] hop_val;

  // Counter range check.
  assign range_err = (item.frame_t2 > gsmhop_pkg::T2_MAX) ||
                     (item.frame_t3 > gsmhop_pkg::T3_MAX);

  // Cyclic hopping: rebuild the frame number and add the offset.
  always_comb begin
    diff = 7'(item.frame_t3) + 7'(gsmhop_pkg::T2_MOD) - 7'(item.frame_t2);
    if (diff >= 7'(2 * gsmhop_pkg::T2_MOD)) begin
      t3_t2_mod = 5'(diff - 7'(2 * gsmhop_pkg::T2_MOD));
    end else if (diff >= 7'(gsmhop_pkg::T2_MOD)) begin
      t3_t2_mod = 5'(diff - 7'(gsmhop_pkg::T2_MOD));
    end else begin
      t3_t2_mod = 5'(diff);
    end
    frame_num = VW'(t3_t2_mod) * VW'(gsmhop_pkg::T3_MOD) + VW'(item.frame_t3) +
                VW'(item.frame_t1) * VW'(gsmhop_pkg::T1_WEIGHT);
    cyc_val   = frame_num + VW'(index_offset);
  end

  // Random hopping: table lookup, masking to the bit length of N and folding.
  always_comb begin
    rn_idx = 7'(hop_seq_number ^ item.frame_t1) + 7'(item.frame_t3);
    rn_val = gsmhop_pkg::rn_lookup(rn_idx);
    rn_sum = 8'(item.frame_t2) + 8'(rn_val);
    n8     = 8'(n);
    for (int i = 0; i < 8; i++) begin
      mask8[i] = |(n8 >> i);
    end
    m8 = rn_sum & mask8;
    t8 = 8'(item.frame_t3) & mask8;
    // (MAIO + S) mod N equals (MAIO + M' + T') mod N on the folded branch.
    hop_val = VW'(index_offset) + VW'(m8) + ((m8 < n8) ? '0 : VW'(t8));
  end

  // Classified beat for the remainder pipeline; an error reduces to zero.
  always_comb begin
    mid_item.range_error = range_err;
    if (range_err) begin
      mid_item.value = '0;
    end else if (hop_seq_number == '0) begin
      mid_item.value = cyc_val;
    end else begin
      mid_item.value = hop_val;
    end
  end

endmodule

/* sv/gsmhop_back.sv */
// Back part: pipelined remainder by N, one restoring step per stage, and the result queue.
`include "gsm_hopping_sequence_generator_top_macros.svh"

module gsmhop_back #(
  parameter  int MAX_ALLOC = gsmhop_pkg::MAX_ALLOC,
  localparam int NW        = $clog2(MAX_ALLOC + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [NW-1:0]         n,
  input  logic                  mid_valid,
  input  gsmhop_pkg::mid_item_t mid_item,
  output logic                  mid_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output gsmhop_pkg::out_item_t out_item
);

  localparam int VW = gsmhop_pkg::VAL_W;
  localparam int SW = VW + NW;

  logic [VW:0]   stg_valid_r;
  logic [VW:0]   err_r;
  logic [VW-1:0] rem_r   [VW+1];
  logic [VW-1:0] rem_nxt [VW];
  logic [SW-1:0] shifted [VW];
  logic          adv;
  logic          out_full;
  gsmhop_pkg::out_item_t res_item;

  // The whole pipeline moves while the result queue has room.
  assign adv     = !out_full;
  assign mid_pop = adv && mid_valid;

  // Stage i subtracts N shifted by VW-1-i when it fits.
  always_comb begin
    for (int i = 0; i < VW; i++) begin
      shifted[i] = SW'(n) << (VW - 1 - i);
      if (SW'(rem_r[i]) >= shifted[i]) begin
        rem_nxt[i] = rem_r[i] - shifted[i][VW-1:0];
      end else begin
        rem_nxt[i] = rem_r[i];
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= '0;
    end else if (adv) begin
      stg_valid_r <= {stg_valid_r[VW-1:0], mid_valid};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= mid_item.value;
      err_r    <= {err_r[VW-1:0], mid_item.range_error};
      for (int i = 0; i < VW; i++) begin
        rem_r[i+1] <= rem_nxt[i];
      end
    end
  end

  // The final remainder is below N, so it fits the index field.
  always_comb begin
    res_item.alloc_index = rem_r[VW][5:0];
    res_item.range_error = err_r[VW];
  end

  gsmhop_fifo #(
    .WIDTH ($bits(gsmhop_pkg::out_item_t)),
    .DEPTH (gsmhop_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (adv && stg_valid_r[VW]),
    .wr_data (res_item),
    .full    (out_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

  `GSMHOP_ASSERT_NEXT(a_stall_holds, !adv, $stable(stg_valid_r), "pipeline moved while stalled")
  `GSMHOP_ASSERT_NEXT(a_mid_taken, mid_pop, stg_valid_r[0], "beat taken from queue was dropped")

endmodule
